>>> sv/utf8_stream_decoder_unit_macros.svh
// Assertion helpers used by the checker file of the decoder.
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define USDEC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define USDEC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/usdec_pkg.sv
package usdec_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;

  // Depth of the descriptor queue between the front and the back.
  localparam int unsigned DESC_DEPTH = 4;
  localparam int unsigned DESC_AW    = $clog2(DESC_DEPTH);
  localparam int unsigned DESC_CW    = $clog2(DESC_DEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Range classes for the second byte of a multi-byte sequence.
  localparam logic [2:0] CLS_ANY = 3'd0;  // 0x80..0xBF
  localparam logic [2:0] CLS_E0  = 3'd1;  // 0xA0..0xBF
  localparam logic [2:0] CLS_ED  = 3'd2;  // 0x80..0x9F
  localparam logic [2:0] CLS_F0  = 3'd3;  // 0x90..0xBF
  localparam logic [2:0] CLS_F4  = 3'd4;  // 0x80..0x8F

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] byte_length;
    logic             error;
    logic             last_of_run;
    logic             stream_done;
  } out_item_t;

  // Work for one accepted byte: err_count replacement results, then at most
  // one good code point.
  typedef struct packed {
    logic [2:0]       err_count;
    logic             has_valid;
    logic [CP_W-1:0]  valid_cp;
    logic [LEN_W-1:0] valid_len;
    logic             eos;
  } desc_t;

  function automatic logic byte_in_range(input logic [2:0] cls, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    unique case (cls)
      CLS_E0: begin
        lo = 8'hA0;
        hi = 8'hBF;
      end
      CLS_ED: begin
        lo = 8'h80;
        hi = 8'h9F;
      end
      CLS_F0: begin
        lo = 8'h90;
        hi = 8'hBF;
      end
      CLS_F4: begin
        lo = 8'h80;
        hi = 8'h8F;
      end
      default: begin
        lo = 8'h80;
        hi = 8'hBF;
      end
    endcase
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

>>> sv/usdec_fifo.sv
module usdec_fifo
  import usdec_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  desc_t wdata,
  output logic  full,
  input  logic  rd,
  output desc_t rdata,
  output logic  avail
);

  desc_t              mem [DESC_DEPTH];
  logic [DESC_AW-1:0] wr_ptr;
  logic [DESC_AW-1:0] rd_ptr;
  logic [DESC_CW-1:0] count;

  function automatic logic [DESC_AW-1:0] ptr_inc(input logic [DESC_AW-1:0] p);
    return (p == DESC_AW'(DESC_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == DESC_CW'(DESC_DEPTH));
  assign avail = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> sv/usdec_front.sv
module usdec_front
  import usdec_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  input  logic     desc_full,
  output logic     desc_push,
  output desc_t    desc
);

  logic [1:0]      held_count;
  logic [2:0]      expected_length;
  logic [2:0]      second_byte_class;
  logic [CP_W-1:0] partial_value;

  logic [1:0]      held_count_next;
  logic [2:0]      expected_length_next;
  logic [2:0]      second_byte_class_next;
  logic [CP_W-1:0] partial_value_next;

  logic [7:0]      b;
  logic            eos;
  logic            s_ascii;
  logic            s_lead;
  logic            s_bad;
  logic [2:0]      s_len;
  logic [2:0]      s_cls;
  logic [CP_W-1:0] s_pay;
  logic [2:0]      cls_sel;
  logic            in_range;
  logic [CP_W-1:0] grown_value;
  logic [2:0]      held_inc;
  logic            accept;

  assign full   = desc_full;
  assign accept = push && !desc_full;

  always_comb begin
    b   = item.byte_value;
    eos = item.end_of_stream;

    // Classify the byte as the start of a new sequence.
    s_ascii = !b[7];
    s_len   = 3'd0;
    s_cls   = CLS_ANY;
    s_pay   = '0;
    s_lead  = 1'b1;
    priority if (b >= 8'hC2 && b <= 8'hDF) begin
      s_len = 3'd2;
      s_pay = CP_W'(b & 8'h1F);
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      s_len = 3'd3;
      s_pay = CP_W'(b & 8'h0F);
      s_cls = (b == 8'hE0) ? CLS_E0 : (b == 8'hED) ? CLS_ED : CLS_ANY;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      s_len = 3'd4;
      s_pay = CP_W'(b & 8'h07);
      s_cls = (b == 8'hF0) ? CLS_F0 : (b == 8'hF4) ? CLS_F4 : CLS_ANY;
    end else begin
      s_lead = 1'b0;
    end
    s_bad = b[7] && !s_lead;

    // Only the second byte has a tightened range.
    cls_sel     = (held_count == 2'd1) ? second_byte_class : CLS_ANY;
    in_range    = byte_in_range(cls_sel, b);
    grown_value = {partial_value[CP_W-7:0], b[5:0]};
    held_inc    = {1'b0, held_count} + 3'd1;

    held_count_next        = '0;
    expected_length_next   = '0;
    second_byte_class_next = CLS_ANY;
    partial_value_next     = '0;
    desc.err_count = '0;
    desc.has_valid = 1'b0;
    desc.valid_cp  = CP_W'(b);
    desc.valid_len = 3'd1;
    desc.eos       = eos;

    if (held_count == 2'd0 || !in_range) begin
      // Flush any held bytes, then treat this byte as a fresh start.
      desc.err_count = {1'b0, held_count};
      if (s_ascii) begin
        desc.has_valid = 1'b1;
      end else if (s_bad) begin
        desc.err_count = desc.err_count + 3'd1;
      end else if (eos) begin
        desc.err_count = desc.err_count + 3'd1;
      end else begin
        held_count_next        = 2'd1;
        expected_length_next   = s_len;
        second_byte_class_next = s_cls;
        partial_value_next     = s_pay;
      end
    end else if (held_inc >= expected_length) begin
      desc.has_valid = 1'b1;
      desc.valid_cp  = grown_value;
      desc.valid_len = expected_length;
    end else if (eos) begin
      desc.err_count = held_inc;
    end else begin
      held_count_next        = held_inc[1:0];
      expected_length_next   = expected_length;
      second_byte_class_next = second_byte_class;
      partial_value_next     = grown_value;
    end

    desc_push = accept && (desc.err_count != 3'd0 || desc.has_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count        <= '0;
      expected_length   <= '0;
      second_byte_class <= CLS_ANY;
      partial_value     <= '0;
    end else if (accept) begin
      held_count        <= held_count_next;
      expected_length   <= expected_length_next;
      second_byte_class <= second_byte_class_next;
      partial_value     <= partial_value_next;
    end
  end

endmodule

>>> sv/usdec_back.sv
module usdec_back
  import usdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  desc_t     desc,
  input  logic      desc_avail,
  output logic      desc_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  logic       out_valid;
  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       is_err;
  logic       last;

  assign empty  = !out_valid;
  assign total  = desc.err_count + {2'b00, desc.has_valid};
  assign load   = desc_avail && (!out_valid || pop);
  assign is_err = (idx < desc.err_count);
  assign last   = ((idx + 3'd1) == total);
  assign desc_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.code_point  <= is_err ? REPLACEMENT_CP : desc.valid_cp;
      result.byte_length <= is_err ? 3'd1 : desc.valid_len;
      result.error       <= is_err;
      result.last_of_run <= last;
      result.stream_done <= last && desc.eos;
    end
  end

endmodule

>>> sv/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder.
// Input channel: one byte per request with an end-of-stream flag; a request
// is taken at a rising edge where push is high and full is low.
// Result channel: decoded code points with their byte length, an error flag
// (U+FFFD, length 1) for every invalid or truncated byte, last_of_run on the
// final result caused by a byte and stream_done on the final result of the
// stream. The head result is shown while empty is low and is taken at an
// edge where pop is high.
// A byte that yields a result is written as one descriptor into the queue;
// the back end loads its results from there into the result register.
// Throughput: one byte per cycle while full is low and one result per cycle
// while pop is high; a byte with several results holds the back end until
// all are out; the four-entry queue absorbs such bursts before full rises.
// A byte that only extends an open sequence yields no result.
// Reset clears the sequence state, the queue and the result valid flag; any
// partially received sequence is discarded without results.
// When the receiver stalls, the result register holds, the queue fills, and
// then full stops further input.
module utf8_stream_decoder_unit
  import usdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  // Front side classifies each byte and writes one descriptor when the byte
  // produces any result.
  desc_t wr_desc;
  desc_t rd_desc;
  logic  desc_push;
  logic  desc_full;
  logic  desc_pop;
  logic  desc_avail;

  usdec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .desc_full (desc_full),
    .desc_push (desc_push),
    .desc      (wr_desc)
  );

  // Short queue so the front keeps taking bytes while the back expands a
  // multi-result descriptor or the receiver stalls.
  usdec_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (desc_push),
    .wdata (wr_desc),
    .full  (desc_full),
    .rd    (desc_pop),
    .rdata (rd_desc),
    .avail (desc_avail)
  );

  // Back side turns each descriptor into its results, one per cycle unless the
  // receiver stalls, into a registered output stage.
  usdec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (rd_desc),
    .desc_avail (desc_avail),
    .desc_pop   (desc_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

>>> sv/usdec_checker.sv
`include "utf8_stream_decoder_unit_macros.svh"

module usdec_checker
  import usdec_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  `USDEC_ASSERT_NXT(a_result_held, clk, rst, !empty && !pop, !empty && $stable(result), "stalled result changed")

  `USDEC_ASSERT_IMP(a_error_form, clk, rst, !empty && result.error, result.code_point == REPLACEMENT_CP && result.byte_length == 3'd1, "error result is not U+FFFD of length 1")

  `USDEC_ASSERT_IMP(a_done_is_last, clk, rst, !empty && result.stream_done, result.last_of_run, "stream_done without last_of_run")

  `USDEC_ASSERT_IMP(a_good_range, clk, rst, !empty && !result.error, result.code_point <= 21'h10FFFF && result.byte_length >= 3'd1 && result.byte_length <= 3'd4, "good result out of range")

endmodule

bind utf8_stream_decoder_unit usdec_checker u_usdec_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

>>> dv/tb_utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps

// Testbench for the UTF-8 stream decoder.
//
// Requests (one byte plus an end-of-stream flag) are queued by the stimulus
// block and handed to the block by a driver that changes its outputs on the
// falling clock edge. The monitor samples both handshakes on the rising edge.
// Every accepted request is run through a local model of the decoder, and
// the code points it yields are stored in order; each result popped from the
// block must match the oldest stored code point in every field.
module tb_utf8_stream_decoder_unit;
  import usdec_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RANDOM_ITEMS  = 95;
  // Slowest correct run: under 200 bytes, at most four results each, every
  // result stalled and every byte delayed by the longest idle_len gap; the
  // limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT   = 200000;
  // Tail run after the drain that catches stray results.
  localparam int TAIL_CYCLES   = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  always #(HALF_PERIOD) clk = ~clk;

  utf8_stream_decoder_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Decoder model state. The held count is one bit wider than in the block
  // so that it can reach four on the last byte of a four-byte sequence.
  logic [2:0]  held_n  = '0;
  logic [2:0]  seq_len = '0;
  logic [2:0]  sec_cls = CLS_ANY;
  logic [20:0] cp_bits = '0;

  out_item_t   burst_q[$];         // results of the request being modeled
  out_item_t   expected_runes[$];  // code points still owed by the block
  in_item_t    pending_bytes[$];   // requests not yet handed to the driver
  logic [7:0]  rune_bytes[$];      // scratch encoding of one random rune

  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          push_gap = 0;
  int          pop_gap = 0;
  bit          push_quiet = 1'b0;
  bit          pop_quiet = 1'b0;
  logic        req_taken = 1'b0;

  // ---------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------

  task automatic add_result(input logic [20:0] cp, input logic [2:0] len, input logic err);
    out_item_t r;
    r.code_point  = cp;
    r.byte_length = len;
    r.error       = err;
    r.last_of_run = 1'b0;
    r.stream_done = 1'b0;
    burst_q.push_back(r);
  endtask

  // Every byte of an abandoned sequence turns into its own replacement.
  task automatic drop_held();
    int k;
    for (k = 0; k < held_n; k++) add_result(REPLACEMENT_CP, 3'd1, 1'b1);
    held_n  = '0;
    seq_len = '0;
    sec_cls = CLS_ANY;
    cp_bits = '0;
  endtask

  // Classify a byte that arrives with no sequence open. The tight ranges for
  // the second byte after E0, ED, F0 and F4 are what reject overlong forms,
  // surrogates and values past U+10FFFF.
  task automatic open_sequence(input logic [7:0] b);
    if (b < 8'h80) begin
      add_result({13'd0, b}, 3'd1, 1'b0);
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      seq_len = 3'd2;
      sec_cls = CLS_ANY;
      cp_bits = {16'd0, b[4:0]};
      held_n  = 3'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      seq_len = 3'd3;
      sec_cls = (b == 8'hE0) ? CLS_E0 : (b == 8'hED) ? CLS_ED : CLS_ANY;
      cp_bits = {17'd0, b[3:0]};
      held_n  = 3'd1;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      seq_len = 3'd4;
      sec_cls = (b == 8'hF0) ? CLS_F0 : (b == 8'hF4) ? CLS_F4 : CLS_ANY;
      cp_bits = {18'd0, b[2:0]};
      held_n  = 3'd1;
    end else begin
      // Stray continuation byte, C0/C1, or F5 and above.
      add_result(REPLACEMENT_CP, 3'd1, 1'b1);
    end
  endtask

  task automatic decode_request(input in_item_t req);
    logic [7:0] b;
    logic [7:0] lo;
    logic [7:0] hi;
    int         n;
    b  = req.byte_value;
    lo = 8'h80;
    hi = 8'hBF;
    burst_q.delete();
    if (held_n == 0) begin
      open_sequence(b);
    end else begin
      if (held_n == 1) begin
        case (sec_cls)
          CLS_E0: lo = 8'hA0;
          CLS_ED: hi = 8'h9F;
          CLS_F0: lo = 8'h90;
          CLS_F4: hi = 8'h8F;
          default: ;
        endcase
      end
      if (b >= lo && b <= hi) begin
        cp_bits = {cp_bits[14:0], b[5:0]};
        held_n  = held_n + 3'd1;
        if (held_n >= seq_len) begin
          add_result(cp_bits, seq_len, 1'b0);
          held_n  = '0;
          seq_len = '0;
          sec_cls = CLS_ANY;
          cp_bits = '0;
        end
      end else begin
        // The breaking byte is looked at again as a fresh start.
        drop_held();
        open_sequence(b);
      end
    end
    if (req.end_of_stream) drop_held();
    n = burst_q.size();
    if (n > 0) begin
      burst_q[n-1].last_of_run = 1'b1;
      burst_q[n-1].stream_done = req.end_of_stream;
    end
    foreach (burst_q[i]) expected_runes.push_back(burst_q[i]);
  endtask

  task automatic check_rune(input out_item_t got);
    out_item_t want;
    if (expected_runes.size() == 0) begin
      $display("%0t: result with none expected: expected none, got cp %h len %0d err %b",
               $time, got.code_point, got.byte_length, got.error);
      mismatch_count++;
    end else begin
      want = expected_runes.pop_front();
      if (got.code_point !== want.code_point) begin
        $display("%0t: code_point expected %h, got %h", $time, want.code_point, got.code_point);
        mismatch_count++;
      end
      if (got.byte_length !== want.byte_length) begin
        $display("%0t: byte_length expected %0d, got %0d", $time, want.byte_length,
                 got.byte_length);
        mismatch_count++;
      end
      if (got.error !== want.error) begin
        $display("%0t: error expected %b, got %b", $time, want.error, got.error);
        mismatch_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run,
                 got.last_of_run);
        mismatch_count++;
      end
      if (got.stream_done !== want.stream_done) begin
        $display("%0t: stream_done expected %b, got %b", $time, want.stream_done,
                 got.stream_done);
        mismatch_count++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: both handshakes are sampled on the rising edge. Inputs only
  // move on the falling edge, so nothing here races with the drivers.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    req_taken <= !rst && push && !full;
    if (!rst) begin
      if (push && !full) begin
        decode_request(item);
        n_taken++;
      end
      if (pop && !empty) check_rune(result);
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Request driver. A request stays on the port until it is taken; then
  // either the next one follows at once or the line goes idle for a while.
  // In quiet stretches no gaps are inserted at all.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !req_taken) begin
      // Still waiting for the current request to be taken.
    end else if (push_gap > 0) begin
      push <= 1'b0;
      push_gap--;
    end else if (pending_bytes.size() > 0) begin
      item <= pending_bytes.pop_front();
      push <= 1'b1;
      if ($urandom_range(0, 19) == 0) push_quiet = !push_quiet;
      push_gap = push_quiet ? 0 : idle_len();
    end else begin
      push <= 1'b0;
    end
  end

  // Result side: stalls start at random, independent of what the block is
  // doing, so they land on every phase of a multi-result burst.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 39) == 0) pop_quiet = !pop_quiet;
      if (!pop_quiet && $urandom_range(0, 3) == 0) pop_gap = idle_len();
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout, %0d results still expected", $time, expected_runes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_byte(input logic [7:0] b, input logic eos);
    in_item_t r;
    r.byte_value    = b;
    r.end_of_stream = eos;
    pending_bytes.push_back(r);
    n_sent++;
  endtask

  // Encode a random scalar value of random length into rune_bytes.
  task automatic make_rune();
    logic [20:0] cp;
    rune_bytes.delete();
    case ($urandom_range(1, 4))
      1: begin
        cp = 21'($urandom_range(0, 'h7F));
        rune_bytes.push_back({1'b0, cp[6:0]});
      end
      2: begin
        cp = 21'($urandom_range('h80, 'h7FF));
        rune_bytes.push_back({3'b110, cp[10:6]});
        rune_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        // Move surrogates out of their block so the rune stays legal.
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h4000;
        rune_bytes.push_back({4'b1110, cp[15:12]});
        rune_bytes.push_back({2'b10, cp[11:6]});
        rune_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        cp = 21'($urandom_range('h10000, 'h10FFFF));
        rune_bytes.push_back({5'b11110, cp[20:18]});
        rune_bytes.push_back({2'b10, cp[17:12]});
        rune_bytes.push_back({2'b10, cp[11:6]});
        rune_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Queue rune_bytes; the stream may end on its last byte.
  task automatic queue_rune(input logic eos);
    int n;
    n = rune_bytes.size();
    for (int k = 0; k < n; k++) queue_byte(rune_bytes[k], eos && (k == n - 1));
  endtask

  // Hold off until every queued request is taken and every result is back.
  task automatic wait_for_drain();
    while (n_taken != n_sent || expected_runes.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int          dir_count;
    int          kind;
    int          cut;
    bit          paused_once;
    paused_once = 1'b0;

    // Directed part: field extremes, every length, each second-byte range
    // at its edge, and the failure cases.
    queue_byte(8'h00, 1'b0);                      // lowest ASCII
    queue_byte(8'h7F, 1'b1);                      // highest ASCII, ends a stream
    queue_byte(8'hDF, 1'b0);                      // U+07FF
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hE0, 1'b0);                      // U+0800, lowest after E0
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hED, 1'b0);                      // U+D7FF, just below surrogates
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hF4, 1'b0);                      // U+10FFFF, the top scalar
    queue_byte(8'h8F, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'h80, 1'b0);                      // stray continuation
    queue_byte(8'hC0, 1'b0);                      // overlong lead
    queue_byte(8'hFF, 1'b0);                      // never a lead
    queue_byte(8'hE0, 1'b0);                      // overlong three-byte form
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'hED, 1'b0);                      // surrogate
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'hF1, 1'b0);                      // three held bytes broken by a
    queue_byte(8'h80, 1'b0);                      // bad lead: four results at once
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hF5, 1'b0);
    queue_byte(8'hF0, 1'b0);                      // truncated at end of stream
    queue_byte(8'h90, 1'b1);
    dir_count = n_sent;

    // Sender pause: nothing more goes in until the directed part is done.
    wait_for_drain();

    // Random part: mostly legal runes with random content, plus broken
    // sequences, loose bytes, and streams that end inside a rune.
    while (n_sent < dir_count + RANDOM_ITEMS) begin
      if (!paused_once && n_sent >= dir_count + RANDOM_ITEMS / 2) begin
        wait_for_drain();
        paused_once = 1'b1;
      end
      kind = $urandom_range(0, 99);
      make_rune();
      if (kind < 65) begin
        queue_rune($urandom_range(0, 9) == 0);
      end else if (kind < 80) begin
        cut = (rune_bytes.size() > 1) ? $urandom_range(1, rune_bytes.size() - 1) : 0;
        if (cut > 0 && $urandom_range(0, 1) == 0) begin
          // Drop the tail; the next rune breaks this one.
          while (rune_bytes.size() > cut) void'(rune_bytes.pop_back());
        end else begin
          rune_bytes[cut] = 8'($urandom_range(0, 255));
        end
        queue_rune($urandom_range(0, 9) == 0);
      end else if (kind < 92) begin
        queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        if (rune_bytes.size() > 1) begin
          cut = $urandom_range(1, rune_bytes.size() - 1);
          while (rune_bytes.size() > cut) void'(rune_bytes.pop_back());
        end
        queue_rune(1'b1);
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Reset is held high from the start and released on a falling edge.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

endmodule

>>> sim.f
+incdir+sv
sv/usdec_pkg.sv
sv/usdec_fifo.sv
sv/usdec_front.sv
sv/usdec_back.sv
sv/utf8_stream_decoder_unit.sv
sv/usdec_checker.sv
dv/tb_utf8_stream_decoder_unit.sv
